// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the sector corrector.
// No dependencies; the including file must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-condition check sampled on every rising clock edge outside reset.
`define CDPQ_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication check: when trig holds, cond must hold in the same cycle.
`define CDPQ_IMPLY(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) else $error(msg);

`endif

// ===== src/cdpq_pkg.sv =====
// Shared constants, GF(256) tables and helpers for the CD sector P/Q corrector.
// No dependencies.
package cdpq_pkg;

	localparam int SECTOR_BYTES = 2352;
	localparam int RAM_W = 9;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ = 2'd1;
	localparam logic [1:0] FUNC_CORRECT = 2'd2;

	localparam logic [1:0] ORDER_Q = 2'd0;
	localparam logic [1:0] ORDER_P = 2'd1;
	localparam logic [1:0] ORDER_QP = 2'd2;
	localparam logic [1:0] ORDER_PQ = 2'd3;

	localparam logic [8:0] GF_POLY = 9'h11d;

	typedef logic [7:0] gf_tab_t [256];

	function automatic logic [7:0] gf_xtime(logic [7:0] a);
		gf_xtime = a[7] ? (({a[6:0], 1'b0}) ^ GF_POLY[7:0]) : {a[6:0], 1'b0};
	endfunction

	function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] x;
		logic [7:0] r;
		x = a;
		r = 8'd0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) r = r ^ x;
			x = gf_xtime(x);
		end
		gf_mul = r;
	endfunction

	function automatic gf_tab_t build_exp();
		gf_tab_t t;
		logic [7:0] v;
		v = 8'd1;
		for (int k = 0; k < 256; k++) begin
			t[k] = v;
			v = gf_xtime(v);
		end
		return t;
	endfunction

	function automatic gf_tab_t build_log();
		gf_tab_t t;
		logic [7:0] v;
		v = 8'd1;
		t[0] = 8'd255;
		for (int k = 0; k < 255; k++) begin
			t[v] = 8'(k);
			v = gf_xtime(v);
		end
		return t;
	endfunction

	function automatic gf_tab_t build_inv();
		gf_tab_t t;
		gf_tab_t e;
		gf_tab_t l;
		e = build_exp();
		l = build_log();
		t[0] = 8'd1;
		for (int k = 1; k < 256; k++) t[k] = e[8'(255 - int'(l[k]))];
		return t;
	endfunction

	localparam gf_tab_t GF_EXP = build_exp();
	localparam gf_tab_t GF_LOG = build_log();
	localparam gf_tab_t GF_INV = build_inv();

endpackage

// ===== src/cdpq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cdpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/cd_sector_pq_parity_corrector_core.sv =====
// Top level of the CD sector P/Q parity corrector: sector RAM and decode sequencer.
// Depends on cdpq_pkg, cdpq_ram and assert_macros.svh.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    func, address, data_byte, erased
// out       output     out_valid / out_ready  read_byte, q_good, p_good
// cfg       input      cfg_we (no wait)       cfg_wdata = pass_order
//
// A write transaction is answered straight from idle, a read after S_RDWAIT
// (the RAM read is registered). A correction walks every codeword: reads of the
// n symbols, a drain state, the decode states S_DEC1, S_DEC2 and for two fixes
// S_DEC3, a read and a write per corrected symbol and a step to the next codeword.
// The single sector RAM port serializes these steps for both passes.
// Reset clears control state only; the sector RAM holds garbage until written.
// in_ready falls while a transaction is in work or while a result waits.
`include "assert_macros.svh"

module cd_sector_pq_parity_corrector_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [11:0] address,
	input  logic [7:0]  data_byte,
	input  logic        erased,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_byte,
	output logic [5:0]  q_good,
	output logic [6:0]  p_good,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDWAIT = 4'd1;
	localparam logic [3:0] S_RUN_RD = 4'd2;
	localparam logic [3:0] S_DRAIN = 4'd3;
	localparam logic [3:0] S_DEC1 = 4'd4;
	localparam logic [3:0] S_DEC2 = 4'd5;
	localparam logic [3:0] S_DEC3 = 4'd6;
	localparam logic [3:0] S_FIX_RD = 4'd7;
	localparam logic [3:0] S_FIX_WR = 4'd8;
	localparam logic [3:0] S_NEXT = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0]  state_q;
	logic [1:0]  pass_order_q;
	logic        pass_p_q;
	logic        second_q;
	logic        half_q;
	logic [5:0]  cw_q;
	logic [5:0]  m_q;
	logic [5:0]  m_s1;
	logic        valid_s1;
	logic [7:0]  s0_q;
	logic [7:0]  s1_q;
	logic [1:0]  ecnt_q;
	logic [5:0]  e0_q;
	logic [5:0]  e1_q;
	logic [7:0]  prod_q;
	logic [7:0]  xb_q;
	logic [5:0]  fpos0_q;
	logic [5:0]  fpos1_q;
	logic [7:0]  fval0_q;
	logic [7:0]  fval1_q;
	logic [1:0]  nfix_q;
	logic        fix_k_q;
	logic        rd_ok_q;
	logic [5:0]  q_good_q;
	logic [6:0]  p_good_q;
	logic        out_valid_q;
	logic [7:0]  read_byte_q;

	logic        accept;
	logic [5:0]  n_len;
	logic [5:0]  n_data;
	logic [5:0]  n_cw;
	logic [1:0]  ne_eff;
	logic [7:0]  xa;
	logic [7:0]  mul_a;
	logic [7:0]  mul_b;
	logic [7:0]  mul_p;
	logic [7:0]  yv;
	logic [7:0]  plog;
	logic [5:0]  fix_pos;
	logic [7:0]  fix_val;
	logic        ram_we;
	logic [11:0] ram_waddr;
	logic [8:0]  ram_wdata;
	logic [11:0] ram_raddr;
	logic [8:0]  ram_rdata;
	logic        addr_ok;
	logic        flag_counts;

	// Sector byte offset of symbol m of codeword cw in the given half.
	function automatic logic [11:0] sym_addr(logic is_p, logic [5:0] m, logic [5:0] cw,
		logic h);
		logic [11:0] v;
		logic [11:0] r;
		if (is_p) begin
			v = 12'(m) * 12'd43 + 12'(cw);
			sym_addr = 12'd12 + {v[10:0], 1'b0} + 12'(h);
		end else if (m < 6'd43) begin
			v = 12'(m) * 12'd44 + 12'(cw) * 12'd43;
			if (v >= 12'd2236) r = v - 12'd2236;
			else if (v >= 12'd1118) r = v - 12'd1118;
			else r = v;
			sym_addr = 12'd12 + {r[10:0], 1'b0} + 12'(h);
		end else if (m == 6'd43) begin
			sym_addr = 12'd2248 + {5'd0, cw, 1'b0} + 12'(h);
		end else begin
			sym_addr = 12'd2300 + {5'd0, cw, 1'b0} + 12'(h);
		end
	endfunction

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign addr_ok = address < 12'(cdpq_pkg::SECTOR_BYTES);

	assign n_len = pass_p_q ? 6'd26 : 6'd45;
	assign n_data = pass_p_q ? 6'd24 : 6'd43;
	assign n_cw = pass_p_q ? 6'd43 : 6'd26;
	// More than two flags fall back to an errors-only decode.
	assign ne_eff = (ecnt_q == 2'd3) ? 2'd0 : ecnt_q;
	assign xa = cdpq_pkg::GF_EXP[8'(n_len - 6'd1 - e0_q)];
	assign yv = s1_q ^ prod_q;
	assign plog = cdpq_pkg::GF_LOG[yv];

	// The one shared GF multiplier; its operands follow the decode step.
	always_comb begin
		mul_a = s1_q ^ prod_q;
		mul_b = cdpq_pkg::GF_INV[xa ^ xb_q];
		if (state_q == S_DEC1) begin
			if (ne_eff != 2'd0) begin
				mul_a = xa;
				mul_b = s0_q;
			end else begin
				mul_a = s1_q;
				mul_b = cdpq_pkg::GF_INV[s0_q];
			end
		end
	end
	assign mul_p = cdpq_pkg::gf_mul(mul_a, mul_b);

	assign fix_pos = fix_k_q ? fpos1_q : fpos0_q;
	assign fix_val = fix_k_q ? fval1_q : fval0_q;
	// Q parity flags never count as erasures.
	assign flag_counts = ram_rdata[8] && (pass_p_q || (m_s1 < 6'd43));

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = address;
		ram_wdata = {erased, data_byte};
		ram_raddr = address;
		unique case (state_q)
			S_IDLE: begin
				ram_we = accept && (func == cdpq_pkg::FUNC_WRITE) && addr_ok;
			end
			S_RUN_RD: begin
				ram_raddr = sym_addr(pass_p_q, m_q, cw_q, half_q);
			end
			S_FIX_RD: begin
				ram_raddr = sym_addr(pass_p_q, fix_pos, cw_q, half_q);
			end
			S_FIX_WR: begin
				ram_we = fix_pos < n_data;
				ram_waddr = sym_addr(pass_p_q, fix_pos, cw_q, half_q);
				ram_wdata = {ram_rdata[8], ram_rdata[7:0] ^ fix_val};
			end
			default: begin
			end
		endcase
	end

	cdpq_ram #(
		.WIDTH(cdpq_pkg::RAM_W),
		.DEPTH(cdpq_pkg::SECTOR_BYTES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_order_q <= cdpq_pkg::ORDER_QP;
		end else if (cfg_we) begin
			pass_order_q <= cfg_wdata;
		end
	end

	// Syndrome and erasure accumulation trails the registered RAM read, gated by valid_s1.
	always_ff @(posedge clk) begin
		m_s1 <= m_q;
		if (state_q == S_NEXT || state_q == S_IDLE) begin
			s0_q <= 8'd0;
			s1_q <= 8'd0;
			e0_q <= 6'd0;
			e1_q <= 6'd0;
		end else if (valid_s1) begin
			s0_q <= s0_q ^ ram_rdata[7:0];
			s1_q <= cdpq_pkg::gf_xtime(s1_q) ^ ram_rdata[7:0];
			if (flag_counts && ecnt_q == 2'd0) e0_q <= m_s1;
			if (flag_counts && ecnt_q == 2'd1) e1_q <= m_s1;
		end
		if (state_q == S_DEC1 || state_q == S_DEC3) prod_q <= mul_p;
		if (state_q == S_RDWAIT) read_byte_q <= rd_ok_q ? ram_rdata[7:0] : 8'd0;
		else if (state_q == S_DONE || accept) read_byte_q <= 8'd0;
		if (accept) rd_ok_q <= addr_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_p_q <= 1'b0;
			second_q <= 1'b0;
			half_q <= 1'b0;
			cw_q <= 6'd0;
			m_q <= 6'd0;
			valid_s1 <= 1'b0;
			ecnt_q <= 2'd0;
			xb_q <= 8'd0;
			fpos0_q <= 6'd0;
			fpos1_q <= 6'd0;
			fval0_q <= 8'd0;
			fval1_q <= 8'd0;
			nfix_q <= 2'd0;
			fix_k_q <= 1'b0;
			q_good_q <= 6'd0;
			p_good_q <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_RUN_RD);
			if (valid_s1 && flag_counts && ecnt_q != 2'd3) ecnt_q <= ecnt_q + 2'd1;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					ecnt_q <= 2'd0;
					if (accept) begin
						if (func == cdpq_pkg::FUNC_READ) begin
							state_q <= S_RDWAIT;
						end else if (func == cdpq_pkg::FUNC_CORRECT) begin
							q_good_q <= 6'd0;
							p_good_q <= 7'd0;
							pass_p_q <= (pass_order_q == cdpq_pkg::ORDER_P) ||
								(pass_order_q == cdpq_pkg::ORDER_PQ);
							second_q <= pass_order_q[1];
							half_q <= 1'b0;
							cw_q <= 6'd0;
							m_q <= 6'd0;
							state_q <= S_RUN_RD;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_RDWAIT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RUN_RD: begin
					if (m_q == n_len - 6'd1) begin
						state_q <= S_DRAIN;
					end else begin
						m_q <= m_q + 6'd1;
					end
				end
				S_DRAIN: begin
					state_q <= S_DEC1;
				end
				S_DEC1: begin
					state_q <= S_DEC2;
				end
				S_DEC2: begin
					fix_k_q <= 1'b0;
					state_q <= S_NEXT;
					if (s0_q == 8'd0 && s1_q == 8'd0) begin
						nfix_q <= 2'd0;
						if (pass_p_q) p_good_q <= p_good_q + 7'd1;
						else q_good_q <= q_good_q + 6'd1;
					end else if (ne_eff == 2'd2) begin
						fpos0_q <= e0_q;
						fpos1_q <= e1_q;
						xb_q <= cdpq_pkg::GF_EXP[8'(n_len - 6'd1 - e1_q)];
						state_q <= S_DEC3;
					end else if (ne_eff == 2'd1) begin
						fpos0_q <= e0_q;
						if (yv == 8'd0) begin
							// The lone erasure explains both syndromes.
							fval0_q <= s0_q;
							nfix_q <= 2'd1;
							state_q <= S_FIX_RD;
							if (pass_p_q) p_good_q <= p_good_q + 7'd1;
							else q_good_q <= q_good_q + 6'd1;
						end else if (yv != xa && plog < 8'(n_len)) begin
							fpos1_q <= n_len - 6'd1 - plog[5:0];
							xb_q <= yv;
							state_q <= S_DEC3;
						end
					end else begin
						if (s0_q != 8'd0 && s1_q != 8'd0 &&
							cdpq_pkg::GF_LOG[prod_q] < 8'(n_len)) begin
							fpos0_q <= n_len - 6'd1 - cdpq_pkg::GF_LOG[prod_q][5:0];
							fval0_q <= s0_q;
							nfix_q <= 2'd1;
							state_q <= S_FIX_RD;
							if (pass_p_q) p_good_q <= p_good_q + 7'd1;
							else q_good_q <= q_good_q + 6'd1;
						end
					end
				end
				S_DEC3: begin
					fval1_q <= mul_p;
					fval0_q <= s0_q ^ mul_p;
					nfix_q <= 2'd2;
					state_q <= S_FIX_RD;
					if (pass_p_q) p_good_q <= p_good_q + 7'd1;
					else q_good_q <= q_good_q + 6'd1;
				end
				S_FIX_RD: begin
					state_q <= S_FIX_WR;
				end
				S_FIX_WR: begin
					if (!fix_k_q && nfix_q == 2'd2) begin
						fix_k_q <= 1'b1;
						state_q <= S_FIX_RD;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					m_q <= 6'd0;
					ecnt_q <= 2'd0;
					state_q <= S_RUN_RD;
					if (cw_q == n_cw - 6'd1) begin
						cw_q <= 6'd0;
						half_q <= !half_q;
						if (half_q) begin
							if (second_q) begin
								second_q <= 1'b0;
								pass_p_q <= !pass_p_q;
							end else begin
								state_q <= S_DONE;
							end
						end
					end else begin
						cw_q <= cw_q + 6'd1;
					end
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_byte = read_byte_q;
	assign q_good = q_good_q;
	assign p_good = p_good_q;

	`CDPQ_CHECK(a_count_bound, (q_good_q <= 6'd52) && (p_good_q <= 7'd86), "count out of range")
	`CDPQ_IMPLY(a_busy_no_ready, state_q != S_IDLE, !in_ready, "ready while busy")
	`CDPQ_IMPLY(a_fix_in_cw, state_q == S_FIX_WR, fix_pos < n_len, "fix outside codeword")
	`CDPQ_IMPLY(a_two_fix_distinct, (state_q == S_FIX_RD) && (nfix_q == 2'd2),
		fpos0_q != fpos1_q, "two fixes at one position")

endmodule

// ===== tb/cd_sector_pq_parity_corrector_core_tb.sv =====
// Self-checking testbench for the CD sector P/Q parity corrector core.
// Depends on cdpq_pkg and cd_sector_pq_parity_corrector_core; stands alone otherwise.
`timescale 1ns / 100ps

module cd_sector_pq_parity_corrector_core_tb;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int ROUNDS = 20;
	localparam int Q_PAR_BASE = 12 + 2236;

	typedef struct {
		logic [7:0] rd;
		logic [5:0] qg;
		logic [6:0] pg;
	} sector_reply_t;

	typedef struct {
		logic [1:0]  f;
		logic [11:0] a;
		logic [7:0]  d;
		logic        e;
		sector_reply_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = cdpq_pkg::FUNC_WRITE;
	logic [11:0] address = '0;
	logic [7:0]  data_byte = '0;
	logic        erased = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  read_byte;
	logic [5:0]  q_good;
	logic [6:0]  p_good;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = cdpq_pkg::ORDER_QP;

	// Predictor state: the sector image, its erasure flags, the good counts
	// and the pass order, all as the block should hold them.
	logic [7:0] sect [cdpq_pkg::SECTOR_BYTES];
	logic       flag [cdpq_pkg::SECTOR_BYTES];
	logic [7:0] clean_img [cdpq_pkg::SECTOR_BYTES];
	logic [5:0] q_count;
	logic [6:0] p_count;
	logic [1:0] order_reg;

	// Codeword scratch used by the decoder and the encoder.
	logic [7:0] cw [45];
	int         era [2];
	logic [7:0] gexp [256];
	int         glog [256];

	sector_reply_t replies_due [$];
	int errors = 0;
	int cycles = 0;
	int snd_idle = 24;
	int rcv_idle = 78;
	int n_corrections = 0;
	int n_reads = 0;
	int n_writes = 0;

	cd_sector_pq_parity_corrector_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.address(address),
		.data_byte(data_byte),
		.erased(erased),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_byte(read_byte),
		.q_good(q_good),
		.p_good(p_good),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 20 ns clock, 10 ns high and 10 ns low.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Global watchdog. A hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("cd_sector_pq_parity_corrector_core verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		errors++;
	endtask

	// GF(256) arithmetic, polynomial 0x11d, generator 2.
	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] x;
		logic [7:0] r;
		x = {1'b0, a};
		r = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) r ^= x[7:0];
			x = x << 1;
			if (x[8]) x ^= 9'h11d;
		end
		return r;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] a);
		return gexp[(255 - glog[a]) % 255];
	endfunction

	// Adds the two solved error values at symbols ia and ib of the scratch word.
	function automatic void solve_pair(input int ia, input logic [7:0] xa, input int ib,
			input logic [7:0] xb, input logic [7:0] s0, input logic [7:0] s1);
		logic [7:0] eb;
		eb = gmul(s1 ^ gmul(xa, s0), ginv(xa ^ xb));
		cw[ia] ^= s0 ^ eb;
		cw[ib] ^= eb;
	endfunction

	// Two-root RS decode of the n-symbol scratch word with ne erasures in era.
	// Symbol i has locator alpha^(n-1-i). Returns 1 on success.
	function automatic bit rs_fix(input int n, input int ne);
		logic [7:0] s0, s1, x, y;
		int p;
		s0 = '0;
		s1 = '0;
		for (int i = 0; i < n; i++) begin
			s0 ^= cw[i];
			s1 = gmul(s1, 8'd2) ^ cw[i];
		end
		if (s0 == 0 && s1 == 0) return 1;
		if (ne == 2) begin
			solve_pair(era[0], gexp[n - 1 - era[0]], era[1], gexp[n - 1 - era[1]], s0, s1);
			return 1;
		end
		if (ne == 1) begin
			x = gexp[n - 1 - era[0]];
			y = s1 ^ gmul(x, s0);
			if (y == 0) begin
				cw[era[0]] ^= s0;
				return 1;
			end
			if (y == x) return 0;
			p = glog[y];
			if (p >= n) return 0;
			solve_pair(era[0], x, n - 1 - p, y, s0, s1);
			return 1;
		end
		if (s0 == 0 || s1 == 0) return 0;
		p = glog[gmul(s1, ginv(s0))];
		if (p >= n) return 0;
		cw[n - 1 - p] ^= s0;
		return 1;
	endfunction

	function automatic int q_addr(input int m, input int nq, input int h);
		return 12 + 2 * ((44 * m + 43 * nq) % 1118) + h;
	endfunction

	function automatic int p_addr(input int m, input int np, input int h);
		return 12 + 2 * (43 * m + np) + h;
	endfunction

	// Q pass over the predicted sector. Parity flags do not count as erasures.
	function automatic int q_pass();
		int good, ne;
		good = 0;
		for (int h = 0; h < 2; h++) begin
			for (int nq = 0; nq < 26; nq++) begin
				ne = 0;
				for (int m = 0; m < 43; m++) begin
					cw[m] = sect[q_addr(m, nq, h)];
					if (flag[q_addr(m, nq, h)]) begin
						if (ne < 2) era[ne] = m;
						ne++;
					end
				end
				cw[43] = sect[Q_PAR_BASE + 2 * nq + h];
				cw[44] = sect[Q_PAR_BASE + 2 * (26 + nq) + h];
				if (ne > 2) ne = 0;
				if (rs_fix(45, ne)) begin
					good++;
					for (int m = 0; m < 43; m++) sect[q_addr(m, nq, h)] = cw[m];
				end
			end
		end
		return good;
	endfunction

	function automatic int p_pass();
		int good, ne;
		good = 0;
		for (int h = 0; h < 2; h++) begin
			for (int np = 0; np < 43; np++) begin
				ne = 0;
				for (int m = 0; m < 26; m++) begin
					cw[m] = sect[p_addr(m, np, h)];
					if (flag[p_addr(m, np, h)]) begin
						if (ne < 2) era[ne] = m;
						ne++;
					end
				end
				if (ne > 2) ne = 0;
				if (rs_fix(26, ne)) begin
					good++;
					for (int m = 0; m < 24; m++) sect[p_addr(m, np, h)] = cw[m];
				end
			end
		end
		return good;
	endfunction

	// Applies one accepted transaction to the predicted state and returns the reply.
	function automatic sector_reply_t sector_apply(input logic [1:0] f, input logic [11:0] a,
			input logic [7:0] d, input logic e);
		sector_reply_t r;
		r.rd = '0;
		if (f == cdpq_pkg::FUNC_WRITE) begin
			if (a < cdpq_pkg::SECTOR_BYTES) begin
				sect[a] = d;
				flag[a] = e;
			end
		end else if (f == cdpq_pkg::FUNC_READ) begin
			if (a < cdpq_pkg::SECTOR_BYTES) r.rd = sect[a];
		end else if (f == cdpq_pkg::FUNC_CORRECT) begin
			q_count = '0;
			p_count = '0;
			case (order_reg)
				cdpq_pkg::ORDER_Q: q_count = 6'(q_pass());
				cdpq_pkg::ORDER_P: p_count = 7'(p_pass());
				cdpq_pkg::ORDER_QP: begin
					q_count = 6'(q_pass());
					p_count = 7'(p_pass());
				end
				default: begin
					p_count = 7'(p_pass());
					q_count = 6'(q_pass());
				end
			endcase
		end
		r.qg = q_count;
		r.pg = p_count;
		return r;
	endfunction

	// Builds a clean sector: random data, then P parity, then Q parity, since
	// the Q codewords cover the P parity bytes but not the other way round.
	task automatic build_clean_sector();
		for (int i = 0; i < cdpq_pkg::SECTOR_BYTES; i++) sect[i] = 8'($urandom);
		for (int h = 0; h < 2; h++) begin
			for (int np = 0; np < 43; np++) begin
				for (int m = 0; m < 26; m++) cw[m] = (m < 24) ? sect[p_addr(m, np, h)] : 8'd0;
				era[0] = 24;
				era[1] = 25;
				void'(rs_fix(26, 2));
				for (int m = 24; m < 26; m++) sect[p_addr(m, np, h)] = cw[m];
			end
		end
		for (int h = 0; h < 2; h++) begin
			for (int nq = 0; nq < 26; nq++) begin
				for (int m = 0; m < 43; m++) cw[m] = sect[q_addr(m, nq, h)];
				cw[43] = '0;
				cw[44] = '0;
				era[0] = 43;
				era[1] = 44;
				void'(rs_fix(45, 2));
				sect[Q_PAR_BASE + 2 * nq + h] = cw[43];
				sect[Q_PAR_BASE + 2 * (26 + nq) + h] = cw[44];
			end
		end
		for (int i = 0; i < cdpq_pkg::SECTOR_BYTES; i++) clean_img[i] = sect[i];
	endtask

	// Sends one transaction and queues its reply. With use_want set, the reply
	// typed into the stimulus rows is queued instead of the predicted one.
	task automatic send(input logic [1:0] f, input logic [11:0] a, input logic [7:0] d,
			input logic e, input bit use_want = 0, input sector_reply_t want = '{0, 0, 0});
		sector_reply_t r;
		if ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		address <= a;
		data_byte <= d;
		erased <= e;
		do @(posedge clk); while (!in_ready);
		r = sector_apply(f, a, d, e);
		if (use_want) r = want;
		replies_due = {replies_due, r};
		if (f == cdpq_pkg::FUNC_CORRECT) n_corrections++;
		if (f == cdpq_pkg::FUNC_READ) n_reads++;
		if (f == cdpq_pkg::FUNC_WRITE) n_writes++;
	endtask

	// Drains every pending reply, then lets the block settle before a
	// register write.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_order(input logic [1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		order_reg = v;
		@(posedge clk);
	endtask

	// Receiver: random backpressure and the in-order compare of each result
	// transaction against the oldest pending reply.
	always @(posedge clk) begin
		sector_reply_t w;
		out_ready <= ($urandom_range(0, 99) >= rcv_idle);
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				report_mismatch("unexpected result, pending", 0, 0);
			end else begin
				w = replies_due.pop_front();
				if (read_byte !== w.rd) report_mismatch("read_byte", read_byte, w.rd);
				if (q_good !== w.qg) report_mismatch("q_good", q_good, w.qg);
				if (p_good !== w.pg) report_mismatch("p_good", p_good, w.pg);
			end
		end
	end

	initial begin
		stim_row_t rows [7];
		int hits [$];
		int k, a;
		logic [1:0] orders [4];

		for (int i = 0; i < 256; i++) glog[i] = 255;
		gexp[0] = 8'd1;
		for (int i = 1; i < 256; i++) gexp[i] = gmul(gexp[i - 1], 8'd2);
		for (int i = 0; i < 255; i++) glog[gexp[i]] = i;
		for (int i = 0; i < cdpq_pkg::SECTOR_BYTES; i++) flag[i] = 1'b0;
		q_count = '0;
		p_count = '0;
		order_reg = cdpq_pkg::ORDER_QP;
		build_clean_sector();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows on the empty sector: only out-of-range addresses and the
		// unused function code, so no unwritten byte is ever read. Counts are
		// still at their reset value of zero.
		rows[0] = '{cdpq_pkg::FUNC_READ, 12'd2352, 8'h00, 1'b0, '{0, 0, 0}};
		rows[1] = '{cdpq_pkg::FUNC_READ, 12'd4095, 8'hff, 1'b1, '{0, 0, 0}};
		rows[2] = '{2'd3, 12'd4095, 8'hff, 1'b1, '{0, 0, 0}};
		rows[3] = '{cdpq_pkg::FUNC_WRITE, 12'd4095, 8'hff, 1'b1, '{0, 0, 0}};
		rows[4] = '{cdpq_pkg::FUNC_WRITE, 12'd2352, 8'h5a, 1'b0, '{0, 0, 0}};
		rows[5] = '{cdpq_pkg::FUNC_READ, 12'd2352, 8'h00, 1'b0, '{0, 0, 0}};
		rows[6] = '{2'd3, 12'd0, 8'h00, 1'b0, '{0, 0, 0}};
		foreach (rows[i]) send(rows[i].f, rows[i].a, rows[i].d, rows[i].e, 1, rows[i].want);

		// Load the whole clean sector, address 0 through 2351, no erasures.
		for (int i = 0; i < cdpq_pkg::SECTOR_BYTES; i++)
			send(cdpq_pkg::FUNC_WRITE, 12'(i), clean_img[i], 1'b0);
		send(cdpq_pkg::FUNC_READ, 12'd0, 8'h00, 1'b0);
		send(cdpq_pkg::FUNC_READ, 12'd2351, 8'h00, 1'b0);
		// A clean sector decodes every codeword, so both counts reach their
		// maxima of 52 and 86 under the reset order.
		send(cdpq_pkg::FUNC_CORRECT, 12'd0, 8'h00, 1'b0, 1, '{0, 52, 86});

		orders = '{cdpq_pkg::ORDER_Q, cdpq_pkg::ORDER_P, cdpq_pkg::ORDER_PQ,
			cdpq_pkg::ORDER_QP};
		for (int r = 0; r < ROUNDS; r++) begin
			if (r == ROUNDS / 3) begin
				snd_idle = 78;
				rcv_idle = 24;
			end else if (r == 2 * ROUNDS / 3) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			if (r % 5 == 0) set_order(orders[(r / 5) % 4]);

			// Corrupt a few bytes, some flagged as erasures. A share of them
			// lands on Q parity, whose flags the block must ignore.
			hits.delete();
			k = $urandom_range(0, 4);
			for (int j = 0; j < k; j++) begin
				if ($urandom_range(0, 4) == 0)
					a = $urandom_range(Q_PAR_BASE, cdpq_pkg::SECTOR_BYTES - 1);
				else a = $urandom_range(12, cdpq_pkg::SECTOR_BYTES - 1);
				hits = {hits, a};
				send(cdpq_pkg::FUNC_WRITE, 12'(a), 8'($urandom), 1'($urandom_range(0, 1)));
			end
			// Odd transactions now and then: ignored addresses and the unused code.
			if ($urandom_range(0, 3) == 0)
				send(2'($urandom_range(0, 3)) | 2'b01,
					12'($urandom_range(cdpq_pkg::SECTOR_BYTES, 4095)),
					8'($urandom), 1'($urandom));
			if ($urandom_range(0, 5) == 0)
				send(cdpq_pkg::FUNC_WRITE, 12'($urandom_range(cdpq_pkg::SECTOR_BYTES, 4095)),
					8'($urandom), 1'b1);

			send(cdpq_pkg::FUNC_CORRECT, 12'($urandom), 8'($urandom), 1'($urandom));
			foreach (hits[j])
				send(cdpq_pkg::FUNC_READ, 12'(hits[j]), 8'($urandom), 1'($urandom));
			repeat (4)
				send(cdpq_pkg::FUNC_READ, 12'($urandom_range(0, cdpq_pkg::SECTOR_BYTES - 1)),
					8'($urandom), 1'b0);

			// Mostly put the sector back to clean with flags cleared, so the next
			// round starts from a well-formed sector. Some rounds leave the damage.
			if ($urandom_range(0, 4) != 0) begin
				for (int i = 0; i < cdpq_pkg::SECTOR_BYTES; i++)
					if (sect[i] != clean_img[i] || flag[i])
						send(cdpq_pkg::FUNC_WRITE, 12'(i), clean_img[i], 1'b0);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d writes, %0d reads and %0d corrections over all four pass orders",
			n_writes, n_reads, n_corrections);
		$display("with erasure and error mixes under three sender and receiver stall profiles");
		if (errors == 0) begin
			$display("cd_sector_pq_parity_corrector_core verification clean");
		end else begin
			$display("cd_sector_pq_parity_corrector_core verification failed");
		end
		$finish;
	end

endmodule
